/* hw/rtl/nfcrfd_pkg.sv */
// shared types and constants for the nfc response frame deframer
// used by nfcrfd_core and nfc_response_frame_deframer; no dependencies
package nfcrfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] PreambleByte = 8'h00;
  localparam logic [ByteW-1:0] StartByte1 = 8'h00;
  localparam logic [ByteW-1:0] StartByte2 = 8'hFF;
  localparam logic [ByteW-1:0] LenOverhead = 8'd2;

  localparam logic [ByteW-1:0] RespCodeReset = 8'd1;
  localparam logic [ByteW-1:0] BufCapReset = 8'd255;
  localparam logic [ByteW-1:0] DirCodeReset = 8'd213;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESPONSE_CODE = 2'd0,
    CFG_BUFFER_CAPACITY = 2'd1,
    CFG_DIRECTION_CODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] response_code;
    logic [ByteW-1:0] buffer_capacity;
    logic [ByteW-1:0] direction_code;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic payload_valid;
    logic frame_done;
    status_e frame_status;
    logic [ByteW-1:0] payload_length;
  } result_t;

endpackage

/* hw/rtl/nfc_response_frame_deframer.sv */
// top level of the nfc response frame deframer: input stage, parser, output stage
// depends on nfcrfd_pkg and nfcrfd_core
//
// usage
//   s_axis carries one received byte per beat (tdata) and a frame start flag
//   (tuser) on the first preamble byte of each frame
//   m_axis returns exactly one result beat per input beat: tuser flags a
//   payload byte, tlast marks the end of frame handling with its status
//   cfg writes the expected response code, buffer capacity and direction code;
//   cfg_ready_o is always high, writes are meant for idle periods
// timing
//   one byte per cycle sustained while m_axis_tready is high; an accepted byte
//   passes the input register, then parser logic into the output register
//   the parser state advances only when a byte moves from the input register
//   into the output register
// reset
//   rst_ni clears both stages, the parser state (idle, waiting for a frame
//   start) and restores the configuration defaults
// backpressure
//   when m_axis_tready is low the output beat holds, the input register fills
//   and s_axis_tready drops until the output is taken
module nfc_response_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // rx_byte
  input  logic                               s_axis_tuser,  // frame_begin
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // payload_byte, payload_index, frame_status, payload_length, zero pad
  output logic [31:0]                        m_axis_tdata,
  output logic                               m_axis_tuser,  // payload_valid
  output logic                               m_axis_tlast,  // frame_done
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nfcrfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [nfcrfd_pkg::ByteW-1:0]       cfg_data_i
);

  nfcrfd_pkg::cfg_t cfg_q;
  nfcrfd_pkg::result_t res;
  nfcrfd_pkg::result_t res_q;

  logic in_valid_q;
  logic [nfcrfd_pkg::ByteW-1:0] in_byte_q;
  logic in_begin_q;
  logic out_valid_q;
  logic out_ready;
  logic step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_code <= nfcrfd_pkg::RespCodeReset;
      cfg_q.buffer_capacity <= nfcrfd_pkg::BufCapReset;
      cfg_q.direction_code <= nfcrfd_pkg::DirCodeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nfcrfd_pkg::CFG_RESPONSE_CODE:   cfg_q.response_code <= cfg_data_i;
        nfcrfd_pkg::CFG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= cfg_data_i;
        nfcrfd_pkg::CFG_DIRECTION_CODE:  cfg_q.direction_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_q || m_axis_tready;
  assign step = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_begin_q <= s_axis_tuser;
    end
  end

  nfcrfd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (in_byte_q),
    .frame_begin_i (in_begin_q),
    .cfg_i         (cfg_q),
    .result_o      (res)
  );

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = res_q.payload_valid;
  assign m_axis_tlast = res_q.frame_done;
  assign m_axis_tdata = {6'b0, res_q.payload_length, res_q.frame_status,
                         res_q.payload_index, res_q.payload_byte};

endmodule

/* hw/rtl/nfcrfd_core.sv */
// frame parsing state machine: one byte in, one result out per step
// depends on nfcrfd_pkg
module nfcrfd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [nfcrfd_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                          frame_begin_i,
  input  nfcrfd_pkg::cfg_t              cfg_i,
  output nfcrfd_pkg::result_t           result_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SC1     = 4'd1,
    PH_SC2     = 4'd2,
    PH_LEN     = 4'd3,
    PH_LCS     = 4'd4,
    PH_TFI     = 4'd5,
    PH_CMD     = 4'd6,
    PH_DATA    = 4'd7,
    PH_DCS     = 4'd8,
    PH_POST    = 4'd9,
    PH_SWALLOW = 4'd10,
    PH_TAIL1   = 4'd11,
    PH_TAIL2   = 4'd12
  } phase_e;

  phase_e phase_q, phase_d;
  logic [nfcrfd_pkg::ByteW-1:0] len_q, len_d;
  logic [nfcrfd_pkg::ByteW-1:0] cnt_q, cnt_d;
  logic [nfcrfd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [nfcrfd_pkg::ByteW-1:0] b;

  assign b = rx_byte_i;

  always_comb begin
    phase_d = phase_q;
    len_d = len_q;
    cnt_d = cnt_q;
    sum_d = sum_q;
    result_o = '0;
    result_o.frame_status = nfcrfd_pkg::STATUS_OK;
    if (frame_begin_i) begin
      if (b == nfcrfd_pkg::PreambleByte) begin
        phase_d = PH_SC1;
      end else begin
        result_o.frame_done = 1'b1;
        result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
        phase_d = PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        PH_SC1: begin
          if (b == nfcrfd_pkg::StartByte1) begin
            phase_d = PH_SC2;
          end else begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end
        PH_SC2: begin
          if (b == nfcrfd_pkg::StartByte2) begin
            phase_d = PH_LEN;
          end else begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end
        PH_LEN: begin
          len_d = b;
          phase_d = PH_LCS;
        end
        PH_LCS: begin
          if (nfcrfd_pkg::ByteW'(len_q + b) == '0) begin
            len_d = len_q - nfcrfd_pkg::LenOverhead;
            phase_d = PH_TFI;
          end else begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end
        PH_TFI: begin
          if (b == cfg_i.direction_code) begin
            sum_d = b;
            phase_d = PH_CMD;
          end else begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end
        PH_CMD: begin
          if (b != cfg_i.response_code) begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end else begin
            sum_d = sum_q + b;
            cnt_d = '0;
            if (len_q > cfg_i.buffer_capacity) begin
              phase_d = PH_SWALLOW;
            end else if (len_q == '0) begin
              phase_d = PH_DCS;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          result_o.payload_byte = b;
          result_o.payload_index = cnt_q;
          result_o.payload_valid = 1'b1;
          sum_d = sum_q + b;
          cnt_d = cnt_q + nfcrfd_pkg::ByteW'(1);
          if (cnt_d == len_q) begin
            phase_d = PH_DCS;
          end
        end
        PH_DCS: begin
          if (nfcrfd_pkg::ByteW'(sum_q + b) == '0) begin
            phase_d = PH_POST;
          end else begin
            result_o.frame_done = 1'b1;
            result_o.frame_status = nfcrfd_pkg::STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end
        PH_POST: begin
          result_o.frame_done = 1'b1;
          result_o.frame_status = nfcrfd_pkg::STATUS_OK;
          result_o.payload_length = len_q;
          phase_d = PH_IDLE;
        end
        PH_SWALLOW: begin
          cnt_d = cnt_q + nfcrfd_pkg::ByteW'(1);
          if (cnt_d == len_q) begin
            phase_d = PH_TAIL1;
          end
        end
        PH_TAIL1: begin
          phase_d = PH_TAIL2;
        end
        PH_TAIL2: begin
          result_o.frame_done = 1'b1;
          result_o.frame_status = nfcrfd_pkg::STATUS_NO_SPACE;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

endmodule

/* test/tb_nfc_response_frame_deframer.sv */
// testbench for nfc_response_frame_deframer: random and malformed frames with stalls
// on both streams, each result beat checked against a built-in frame parser
// depends on nfcrfd_pkg and the deframer rtl
`timescale 1ns / 100ps

module tb_nfc_response_frame_deframer;
  import nfcrfd_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE, P_SC1, P_SC2, P_LEN, P_LCS, P_TFI, P_CMD, P_DATA, P_DCS, P_POST,
    P_SWALLOW, P_TAIL1, P_TAIL2
  } frame_phase_e;

  typedef enum int unsigned {
    F_NONE, F_PREAMBLE, F_START1, F_START2, F_LEN_SUM, F_DIRECTION, F_RESPONSE,
    F_DATA_SUM, F_CUT, F_STRAY_BEGIN
  } fault_e;

  typedef struct packed {
    logic       frame_begin;
    logic [7:0] rx_byte;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_data_i = '0;

  rx_item_t    rx_bytes_q[$];
  result_t     deframed_q[$];

  // parser copy
  logic [7:0]   cfg_resp = RespCodeReset;
  logic [7:0]   cfg_cap = BufCapReset;
  logic [7:0]   cfg_dir = DirCodeReset;
  frame_phase_e fp = P_IDLE;
  logic [7:0]   plen_reg = 8'd0;
  logic [7:0]   seen_count = 8'd0;
  logic [7:0]   data_sum = 8'd0;

  bit          byte_taken = 1'b0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned hold_left = 0;
  int unsigned frame_bytes = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  result_t     got;
  result_t     want;
  result_t     pred;

  nfc_response_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void close_frame(inout result_t r, input status_e st,
                                      input logic [7:0] len);
    r.frame_done = 1'b1;
    r.frame_status = st;
    r.payload_length = len;
    fp = P_IDLE;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b, input logic first);
    result_t r;
    r = '0;
    if (first) begin
      if (b == PreambleByte) fp = P_SC1;
      else close_frame(r, STATUS_INVALID, 8'd0);
      return r;
    end
    case (fp)
      P_SC1: begin
        if (b == StartByte1) fp = P_SC2;
        else close_frame(r, STATUS_INVALID, 8'd0);
      end
      P_SC2: begin
        if (b == StartByte2) fp = P_LEN;
        else close_frame(r, STATUS_INVALID, 8'd0);
      end
      P_LEN: begin
        plen_reg = b;
        fp = P_LCS;
      end
      P_LCS: begin
        if (8'(plen_reg + b) == 8'd0) begin
          plen_reg = plen_reg - LenOverhead;
          fp = P_TFI;
        end else begin
          close_frame(r, STATUS_INVALID, 8'd0);
        end
      end
      P_TFI: begin
        if (b == cfg_dir) begin
          data_sum = b;
          fp = P_CMD;
        end else begin
          close_frame(r, STATUS_INVALID, 8'd0);
        end
      end
      P_CMD: begin
        if (b != cfg_resp) begin
          close_frame(r, STATUS_INVALID, 8'd0);
        end else begin
          data_sum = data_sum + b;
          seen_count = 8'd0;
          if (plen_reg > cfg_cap) fp = P_SWALLOW;
          else if (plen_reg == 8'd0) fp = P_DCS;
          else fp = P_DATA;
        end
      end
      P_DATA: begin
        r.payload_byte = b;
        r.payload_index = seen_count;
        r.payload_valid = 1'b1;
        data_sum = data_sum + b;
        seen_count = seen_count + 8'd1;
        if (seen_count == plen_reg) fp = P_DCS;
      end
      P_DCS: begin
        if (8'(data_sum + b) == 8'd0) fp = P_POST;
        else close_frame(r, STATUS_INVALID, 8'd0);
      end
      P_POST: close_frame(r, STATUS_OK, plen_reg);
      P_SWALLOW: begin
        seen_count = seen_count + 8'd1;
        if (seen_count == plen_reg) fp = P_TAIL1;
      end
      P_TAIL1: fp = P_TAIL2;
      P_TAIL2: close_frame(r, STATUS_NO_SPACE, 8'd0);
      default: fp = P_IDLE;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] fault_mask(input fault_e at, input fault_e fault,
                                            input logic [7:0] flip);
    return (at == fault) ? flip : 8'h00;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] g,
                                 input logic [7:0] w);
    if (error_count < 40)
      $display("mismatch on %s at result %0d: got %0h, want %0h", field, results_seen, g, w);
    error_count++;
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || byte_taken)) begin
      byte_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx_bytes_q[0].rx_byte;
        s_axis_tuser <= rx_bytes_q[0].frame_begin;
        void'(rx_bytes_q.pop_front());
        if (tx_idle_on) tx_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on) rx_stall = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred = deframe_byte(s_axis_tdata, s_axis_tuser);
        deframed_q.push_back(pred);
        byte_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_byte = m_axis_tdata[7:0];
        got.payload_index = m_axis_tdata[15:8];
        got.frame_status = status_e'(m_axis_tdata[17:16]);
        got.payload_length = m_axis_tdata[25:18];
        got.payload_valid = m_axis_tuser;
        got.frame_done = m_axis_tlast;
        if (deframed_q.size() == 0) begin
          report_mismatch("beat with nothing expected", m_axis_tdata[7:0], 8'h00);
        end else begin
          want = deframed_q.pop_front();
          if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
          if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", got.payload_index, want.payload_index);
          if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", 8'(got.payload_valid), 8'(want.payload_valid));
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", 8'(got.frame_done), 8'(want.frame_done));
          if (got.frame_status !== want.frame_status)
            report_mismatch("frame_status", 8'(got.frame_status), 8'(want.frame_status));
          if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", got.payload_length, want.payload_length);
        end
        results_seen++;
      end
    end
  end

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RESPONSE_CODE: cfg_resp = val;
      CFG_BUFFER_CAPACITY: cfg_cap = val;
      CFG_DIRECTION_CODE: cfg_dir = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cfg(input logic [7:0] resp, input logic [7:0] cap,
                         input logic [7:0] dir);
    write_cfg(CFG_RESPONSE_CODE, resp);
    write_cfg(CFG_BUFFER_CAPACITY, cap);
    write_cfg(CFG_DIRECTION_CODE, dir);
  endtask

  task automatic push_frame(input int unsigned plen, input fault_e fault,
                            input logic [7:0] data0);
    rx_item_t    frm[$];
    logic [7:0]  len;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  flip;
    int unsigned i;
    int unsigned cut;
    flip = $urandom_range(255, 1);
    len = 8'(plen + LenOverhead);
    frm.push_back({1'b1, PreambleByte ^ fault_mask(F_PREAMBLE, fault, flip)});
    frm.push_back({1'b0, StartByte1 ^ fault_mask(F_START1, fault, flip)});
    frm.push_back({1'b0, StartByte2 ^ fault_mask(F_START2, fault, flip)});
    frm.push_back({1'b0, len});
    b = (-len) ^ fault_mask(F_LEN_SUM, fault, flip);
    frm.push_back({1'b0, b});
    frm.push_back({1'b0, cfg_dir ^ fault_mask(F_DIRECTION, fault, flip)});
    frm.push_back({1'b0, cfg_resp ^ fault_mask(F_RESPONSE, fault, flip)});
    sum = cfg_dir + cfg_resp;
    for (i = 0; i < plen; i++) begin
      b = (i == 0) ? data0 : 8'($urandom());
      sum = sum + b;
      frm.push_back({1'b0, b});
    end
    b = (-sum) ^ fault_mask(F_DATA_SUM, fault, flip);
    frm.push_back({1'b0, b});
    frm.push_back({1'b0, 8'($urandom())});
    if (fault == F_STRAY_BEGIN) begin
      i = $urandom_range(frm.size() - 1, 1);
      frm[i].frame_begin = 1'b1;
    end
    cut = (fault == F_CUT) ? $urandom_range(frm.size() - 1, 1) : frm.size();
    for (i = 0; i < cut; i++) rx_bytes_q.push_back(frm[i]);
    frame_bytes += cut;
  endtask

  task automatic fill_random(input int unsigned goal);
    int unsigned roll;
    int unsigned plen;
    int unsigned n;
    fault_e      fault;
    frame_bytes = 0;
    while (frame_bytes < goal) begin
      roll = $urandom_range(99, 0);
      if (roll < 70)
        plen = $urandom_range((cfg_cap < 10) ? cfg_cap : 10, 0);
      else if (roll < 85 && cfg_cap < 255)
        plen = $urandom_range((cfg_cap > 245) ? 255 : cfg_cap + 10, cfg_cap + 1);
      else if (roll < 98)
        plen = $urandom_range((cfg_cap < 40) ? cfg_cap : 40, 0);
      else
        plen = $urandom_range(255, 0);
      fault = ($urandom_range(99, 0) < 70) ? F_NONE :
              fault_e'($urandom_range(F_STRAY_BEGIN, F_PREAMBLE));
      push_frame(plen, fault, 8'($urandom()));
      // line noise between frames
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        n = $urandom_range(4, 1);
        repeat (n) rx_bytes_q.push_back({1'b0, 8'($urandom())});
      end else if (roll < 13) begin
        rx_bytes_q.push_back({1'b1, 8'($urandom())});
      end
    end
  endtask

  task automatic settle();
    while (rx_bytes_q.size() != 0 || deframed_q.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int unsigned fill_level;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ignored byte, empty payload, bad preamble, one byte payload
    rx_bytes_q.push_back({1'b0, 8'h5A});
    push_frame(0, F_NONE, 8'h00);
    rx_bytes_q.push_back({1'b1, 8'hFF});
    push_frame(1, F_NONE, 8'hFF);
    push_frame(1, F_NONE, 8'h00);
    fill_random(200);
    settle();

    set_cfg(8'h00, 8'h00, 8'h00);
    fill_random(200);
    settle();

    set_cfg(8'hFF, 8'hFF, 8'hFF);
    push_frame(254, F_NONE, 8'h00);
    push_frame(255, F_NONE, 8'hFF);
    fill_random(200);
    settle();

    // long output hold-off while the sender keeps offering bytes
    set_cfg(8'h4B, 8'd8, DirCodeReset);
    fill_random(200);
    fill_level = rx_bytes_q.size();
    while (rx_bytes_q.size() + 20 > fill_level) @(negedge clk_i);
    hold_request = 1'b1;
    settle();

    set_cfg(8'($urandom()), 8'($urandom()), 8'($urandom()));
    fill_random(200);
    settle();

    // back to back on both streams
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_cfg(8'($urandom()), 8'($urandom_range(40, 0)), DirCodeReset);
    fill_random(200);
    settle();

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/nfcrfd_pkg.sv
hw/rtl/nfcrfd_core.sv
hw/rtl/nfc_response_frame_deframer.sv
test/tb_nfc_response_frame_deframer.sv
